/* hdl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define LPRL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define LPRL_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LPRL_ASSERT(label, clk, rst_n, prop, msg)
`define LPRL_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* hdl/lprl_pkg.sv */
`default_nettype none

package lprl_pkg;

    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int IP_W   = 32;
    localparam int PORT_W = 4;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   hop;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   prefix;
    } t_route;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  entry_index;
        t_route            route;
        logic [IP_W-1:0]   lookup_address;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [IP_W-1:0]   hop_address;
        logic [PORT_W-1:0] out_port;
        logic [IDX_W-1:0]  matched_index;
    } t_rsp;

endpackage

`default_nettype wire

/* hdl/lprl_table.sv */
`default_nettype none

// Route table RAM: one write port, one read port, registered read data.
module lprl_table
    import lprl_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_route        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_route             o_rd_data
);

    t_route r_mem [DEPTH];
    t_route r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* hdl/lprl_walk.sv */
`default_nettype none

`include "assert_macros.svh"

// Request sequencer: stores routes, walks the table for lookups,
// tracks the best match and holds the result register.
module lprl_walk
    import lprl_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CNT_W-1:0] i_active,
    input  wire logic             i_s_valid,
    output logic                  o_s_ready,
    input  wire t_req             i_s_req,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    output t_rsp                  o_m_rsp,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output t_route                o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  wire t_route           i_rd_data
);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state            r_state, n_state;
    logic [IP_W-1:0]   r_addr, n_addr;
    logic [CW-1:0]     r_limit, n_limit;
    logic [CW-1:0]     r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic [IP_W-1:0]   r_best_mask, n_best_mask;
    logic [IP_W-1:0]   r_best_hop, n_best_hop;
    logic [PORT_W-1:0] r_best_port, n_best_port;
    logic              r_o_valid, n_o_valid;
    t_rsp              r_o_rsp, n_o_rsp;

    logic s_fire;
    logic rd_en;
    logic match;
    logic better;

    assign o_s_ready = (r_state == S_IDLE);
    assign s_fire    = i_s_valid && o_s_ready;

    assign o_wr_en   = s_fire && (i_s_req.kind == KIND_WRITE)
                       && (32'(i_s_req.entry_index) < 32'(DEPTH));
    assign o_wr_addr = AW'(i_s_req.entry_index);
    assign o_wr_data = i_s_req.route;

    assign rd_en     = (r_state == S_WALK) && (r_issue < r_limit);
    assign o_rd_en   = rd_en;
    assign o_rd_addr = r_issue[AW-1:0];

    assign match  = ((r_addr & i_rd_data.mask) == i_rd_data.prefix);
    assign better = !r_found || (i_rd_data.mask > r_best_mask);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_limit     = r_limit;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_mask = r_best_mask;
        n_best_hop  = r_best_hop;
        n_best_port = r_best_port;
        n_o_valid   = r_o_valid && !i_m_ready;
        n_o_rsp     = r_o_rsp;

        // compare stage, in the cycle after the read is issued
        if (r_pend && match && better) begin
            n_found     = 1'b1;
            n_best_idx  = r_pend_idx;
            n_best_mask = i_rd_data.mask;
            n_best_hop  = i_rd_data.hop;
            n_best_port = i_rd_data.port;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (i_s_req.kind == KIND_LOOKUP)) begin
                    n_state = S_WALK;
                    n_addr  = i_s_req.lookup_address;
                    n_issue = '0;
                    n_found = 1'b0;
                    if (32'(i_active) > 32'(DEPTH)) begin
                        n_limit = CW'(DEPTH);
                    end else begin
                        n_limit = CW'(i_active);
                    end
                end
            end
            S_WALK: begin
                if (rd_en) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[AW-1:0];
                    n_issue    = r_issue + CW'(1);
                end else if (!r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_m_ready) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                    if (r_found) begin
                        n_o_rsp.hit           = 1'b1;
                        n_o_rsp.hop_address   = r_best_hop;
                        n_o_rsp.out_port      = r_best_port;
                        n_o_rsp.matched_index = IDX_W'(r_best_idx);
                    end else begin
                        n_o_rsp = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
            r_issue   <= '0;
            r_limit   <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
            r_issue   <= n_issue;
            r_limit   <= n_limit;
        end
        r_addr      <= n_addr;
        r_pend_idx  <= n_pend_idx;
        r_best_idx  <= n_best_idx;
        r_best_mask <= n_best_mask;
        r_best_hop  <= n_best_hop;
        r_best_port <= n_best_port;
        r_o_rsp     <= n_o_rsp;
    end

    assign o_m_valid = r_o_valid;
    assign o_m_rsp   = r_o_rsp;

    `LPRL_ASSERT(a_pend_in_range, i_clk, i_rst_n, r_pend |-> (CW'(r_pend_idx) < r_limit), "compare of slot beyond active range")
    `LPRL_ASSERT(a_result_after_walk, i_clk, i_rst_n, $rose(r_o_valid) |-> $past(r_state == S_DONE), "result loaded before walk finished")
    `LPRL_ASSERT(a_miss_zero, i_clk, i_rst_n, (r_o_valid && !r_o_rsp.hit) |-> (r_o_rsp.hop_address == '0 && r_o_rsp.out_port == '0 && r_o_rsp.matched_index == '0), "miss result carries nonzero fields")
    `LPRL_ASSERT(a_lookup_starts, i_clk, i_rst_n, (s_fire && i_s_req.kind == KIND_LOOKUP) |=> (r_state == S_WALK && r_issue == '0), "lookup did not start a walk")
    `LPRL_NEVER(a_write_during_walk, i_clk, i_rst_n, o_wr_en && r_state != S_IDLE, "table write while walking")

endmodule

`default_nettype wire

/* hdl/longest_prefix_route_lookup_core.sv */
`default_nettype none

// IPv4 longest-prefix route lookup.
//
// Requests arrive on the s_axis channel; tuser selects the kind (0 stores one
// route at entry_index, 1 looks up lookup_address). Stores give no result.
// Each lookup gives one result on m_axis: tuser carries the hit flag, tdata
// the next hop, port and slot of the best route (all zero on a miss).
// The best route is the matching slot with the numerically largest mask among
// slots 0 .. N-1; the lowest slot wins a tie. A store is written to the RAM
// when it is accepted. A lookup walks the table through the single RAM read
// port, one slot per cycle, over N = min(active_entries, TABLE_DEPTH) slots,
// then loads its result once the last slot is compared; the next request is
// taken the cycle after the result is loaded. The result sits in an output
// register: a stalled m_axis_tready holds it and the block keeps accepting
// requests, stalling only when a new lookup result needs that register.
// Reset clears the control logic and sets active_entries to 0; the route RAM
// is not cleared, so slots must be stored before they are made active.
// active_entries is written through i_cfg_wr_en/i_cfg_wr_data; the user must
// write it only while no lookup is in flight, the block does not enforce it.
module longest_prefix_route_lookup_core
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [10:0]  i_cfg_wr_data,  // active_entries
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [9:0] entry_index, [41:10] entry_prefix, [73:42] entry_mask,
    // [105:74] entry_hop, [109:106] entry_port, [141:110] lookup_address,
    // [143:142] zero
    input  wire logic [143:0] s_axis_tdata,
    input  wire logic [0:0]   s_axis_tuser,   // [0] kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] hop_address, [35:32] out_port, [45:36] matched_index, [47:46] zero
    output logic [47:0]       m_axis_tdata,
    output logic [0:0]        m_axis_tuser    // [0] hit
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0] r_active;
    t_req             s_req;
    t_rsp             m_rsp;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_route           wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    t_route           rd_data;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    // unpack request
    assign s_req.kind           = s_axis_tuser[0];
    assign s_req.entry_index    = s_axis_tdata[9:0];
    assign s_req.route.prefix   = s_axis_tdata[41:10];
    assign s_req.route.mask     = s_axis_tdata[73:42];
    assign s_req.route.hop      = s_axis_tdata[105:74];
    assign s_req.route.port     = s_axis_tdata[109:106];
    assign s_req.lookup_address = s_axis_tdata[141:110];

    lprl_walk #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_active  (r_active),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_req   (s_req),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_rsp   (m_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    lprl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // pack result
    assign m_axis_tdata = {2'b00, m_rsp.matched_index, m_rsp.out_port, m_rsp.hop_address};
    assign m_axis_tuser = m_rsp.hit;

endmodule

`default_nettype wire

/* test/tb_longest_prefix_route_lookup_core.sv */
`timescale 1ns / 1ps

// Self-checking bench for the route lookup core.
// A local mirror of the route table predicts every lookup result at the
// moment the request is accepted; a monitor pops and compares each result.
// The whole table is loaded before any large active_entries setting, so no
// lookup ever walks a slot that was never stored.
module tb_longest_prefix_route_lookup_core;
    import lprl_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int CFG_MAX      = (1 << CNT_W) - 1;
    // A store is written when accepted; extra idle clocks before touching the config.
    localparam int WRITE_SETTLE = 4;
    localparam int REPORT_CAP   = 200;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] i_cfg_wr_data = '0;      // active_entries
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // [9:0] entry_index, [41:10] entry_prefix, [73:42] entry_mask,
    // [105:74] entry_hop, [109:106] entry_port, [141:110] lookup_address,
    // [143:142] zero
    logic [143:0]     s_axis_tdata  = '0;
    logic [0:0]       s_axis_tuser  = '0;      // [0] kind
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [31:0] hop_address, [35:32] out_port, [45:36] matched_index, [47:46] zero
    logic [47:0]      m_axis_tdata;
    logic [0:0]       m_axis_tuser;            // [0] hit

    // Mirror of the route table and the active_entries register.
    logic [IP_W-1:0]   route_prefix_tbl [TABLE_DEPTH];
    logic [IP_W-1:0]   route_mask_tbl   [TABLE_DEPTH];
    logic [IP_W-1:0]   route_hop_tbl    [TABLE_DEPTH];
    logic [PORT_W-1:0] route_port_tbl   [TABLE_DEPTH];
    int                active_entries_cfg = 0;

    // Predicted lookup results, oldest first.
    t_rsp expected_lookups [$];
    int   mismatch_count  = 0;

    // Idling knobs (percent per cycle) and the one-shot long receiver hold-off.
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    longest_prefix_route_lookup_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Slots actually walked: the walk is clamped at the table depth.
    function automatic int walk_length();
        return (active_entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : active_entries_cfg;
    endfunction

    // Longest-prefix search over the mirror. Masks compare as plain unsigned
    // numbers (non-contiguous ones too); strict > keeps the lowest slot on a tie.
    function automatic t_rsp predict_lookup(input logic [IP_W-1:0] addr);
        t_rsp             rsp;
        logic [IP_W-1:0]  best_mask;
        rsp       = '0;
        best_mask = '0;
        for (int i = 0; i < walk_length(); i++) begin
            if ((addr & route_mask_tbl[i]) == route_prefix_tbl[i] &&
                (!rsp.hit || route_mask_tbl[i] > best_mask)) begin
                rsp.hit           = 1'b1;
                rsp.hop_address   = route_hop_tbl[i];
                rsp.out_port      = route_port_tbl[i];
                rsp.matched_index = IDX_W'(i);
                best_mask         = route_mask_tbl[i];
            end
        end
        return rsp;
    endfunction

    function automatic t_route route_entry(input logic [IP_W-1:0] prefix,
                                           input logic [IP_W-1:0] mask,
                                           input logic [IP_W-1:0] hop,
                                           input logic [PORT_W-1:0] port);
        t_route rt;
        rt.prefix = prefix;
        rt.mask   = mask;
        rt.hop    = hop;
        rt.port   = port;
        return rt;
    endfunction

    // Mask lengths lean on byte boundaries so equal masks (ties) show up often;
    // a fifth of masks are arbitrary bit patterns, a few prefixes sit off-mask.
    function automatic t_route random_route();
        t_route rt;
        int     len;
        len     = ($urandom_range(1) == 0) ? 8 * $urandom_range(4) : $urandom_range(32);
        rt.mask = ($urandom_range(9) < 2) ? $urandom() : (32'hFFFF_FFFF << (32 - len));
        rt.prefix = ($urandom_range(9) < 8) ? ($urandom() & rt.mask) : $urandom();
        rt.hop    = $urandom();
        rt.port   = PORT_W'($urandom_range(15));
        return rt;
    endfunction

    // Mostly an address inside some active route, the rest fully random.
    function automatic logic [IP_W-1:0] lookup_target();
        int slot;
        if (walk_length() == 0 || $urandom_range(3) == 0)
            return $urandom();
        slot = $urandom_range(walk_length() - 1);
        return route_prefix_tbl[slot] | ($urandom() & ~route_mask_tbl[slot]);
    endfunction

    task automatic report_mismatch(input string what, input logic [IP_W-1:0] got,
                                   input logic [IP_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one request, hold it until accepted, then update the prediction.
    task automatic send_request(input t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.kind;
        s_axis_tdata  <= {2'b00, rq.lookup_address, rq.route.port, rq.route.hop,
                          rq.route.mask, rq.route.prefix, rq.entry_index};
        do @(posedge i_clk); while (!s_axis_tready);
        if (rq.kind == KIND_WRITE) begin
            route_prefix_tbl[rq.entry_index] = rq.route.prefix;
            route_mask_tbl[rq.entry_index]   = rq.route.mask;
            route_hop_tbl[rq.entry_index]    = rq.route.hop;
            route_port_tbl[rq.entry_index]   = rq.route.port;
        end else begin
            expected_lookups.push_back(predict_lookup(rq.lookup_address));
        end
    endtask

    // Store request; the unused address field carries noise.
    task automatic send_route(input int slot, input t_route rt);
        t_req rq;
        rq.kind           = KIND_WRITE;
        rq.entry_index    = IDX_W'(slot);
        rq.route          = rt;
        rq.lookup_address = $urandom();
        send_request(rq);
    endtask

    // Lookup request; the unused route fields carry noise.
    task automatic send_lookup(input logic [IP_W-1:0] addr);
        t_req rq;
        rq.kind           = KIND_LOOKUP;
        rq.entry_index    = IDX_W'($urandom_range(TABLE_DEPTH - 1));
        rq.route          = random_route();
        rq.lookup_address = addr;
        send_request(rq);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge i_clk);
        repeat (WRITE_SETTLE) @(posedge i_clk);
    endtask

    // Config writes only with nothing in flight.
    task automatic set_active_entries(input int value);
        wait_until_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_entries_cfg = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Right after reset nothing is active: every lookup misses.
    task automatic test_empty_table();
        send_lookup('0);
        send_lookup('1);
        send_lookup($urandom());
    endtask

    // Load every slot so any active_entries value is legal from here on.
    task automatic test_fill_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_route(i, random_route());
    endtask

    task automatic test_directed_routes();
        set_active_entries(8);
        send_route(0, route_entry(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15)); // default
        send_route(1, route_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));  // host
        send_route(2, route_entry(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd3));
        send_route(3, route_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'd4));
        send_route(4, route_entry(32'h0A01_0000, 32'hFFFF_0000, 32'h0BAD_0001, 4'd5)); // tie
        send_route(5, route_entry(32'h0012_0034, 32'h00FF_00FF, 32'h1234_5678, 4'd6)); // gappy
        send_route(6, route_entry(32'h0000_0001, 32'hFFFF_0000, 32'h5555_AAAA, 4'd7)); // dead
        send_route(7, route_entry(32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 4'd8));
        send_lookup(32'hFFFF_FFFF);     // host route beats default
        send_lookup(32'h0A01_0203);     // equal /16 masks, lower slot wins
        send_lookup(32'h0A02_0304);     // only the /8
        send_lookup(32'hAB12_CD34);     // non-contiguous mask beats default
        send_lookup(32'h0000_0001);     // off-mask prefix never matches
        send_lookup(32'hC0A8_0105);
        // Drop the default route: a real miss with active entries.
        set_active_entries(2);
        send_route(0, route_entry(32'h0100_0000, 32'hFF00_0000, 32'h0101_0101, 4'd1));
        send_lookup(32'h0200_0000);
        send_lookup(32'h0102_0304);
    endtask

    // Full-depth walks and register values above the depth (saturation).
    task automatic test_active_saturation();
        send_route(TABLE_DEPTH - 1,
                   route_entry(32'hC633_6401, 32'hFFFF_FFFF, 32'h0A00_0001, 4'd9));
        set_active_entries(TABLE_DEPTH);
        send_lookup(32'hC633_6401);
        send_lookup(lookup_target());
        set_active_entries(CFG_MAX);
        send_lookup(32'hC633_6401);
        send_lookup(lookup_target());
        set_active_entries(TABLE_DEPTH + 1);
        send_lookup(lookup_target());
    endtask

    // Mixed stores and lookups under each idling pattern, small tables mostly.
    task automatic test_random_traffic();
        int sender_idle [4] = '{0, 58, 0, 24};
        int recv_stall  [4] = '{0, 0, 58, 24};
        int slot;
        for (int p = 0; p < 4; p++) begin
            set_idling(sender_idle[p], recv_stall[p]);
            for (int s = 0; s < 3; s++) begin
                set_active_entries(($urandom_range(7) == 0) ? 0 : $urandom_range(160, 1));
                repeat (48) begin
                    if ($urandom_range(9) < 3) begin
                        slot = (walk_length() > 0 && $urandom_range(3) != 0) ?
                               $urandom_range(walk_length() - 1) :
                               $urandom_range(TABLE_DEPTH - 1);
                        send_route(slot, random_route());
                    end else begin
                        send_lookup(lookup_target());
                    end
                end
            end
        end
    endtask

    // Receiver goes quiet for a long stretch while requests keep coming:
    // the result register fills and the core must stall its input.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        set_active_entries(4);
        hold_off_cycles = 400;
        for (int k = 0; k < 16; k++) begin
            if (k % 4 == 3)
                send_route($urandom_range(TABLE_DEPTH - 1), random_route());
            else
                send_lookup(lookup_target());
        end
    endtask

    // Result-side ready: random stalls, or a counted hold-off when requested.
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with no lookup pending", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_lookups.pop_front();
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", IP_W'(m_axis_tuser[0]), IP_W'(want.hit));
                if (m_axis_tdata[31:0] !== want.hop_address)
                    report_mismatch("hop_address", m_axis_tdata[31:0], want.hop_address);
                if (m_axis_tdata[35:32] !== want.out_port)
                    report_mismatch("out_port", IP_W'(m_axis_tdata[35:32]),
                                    IP_W'(want.out_port));
                if (m_axis_tdata[45:36] !== want.matched_index)
                    report_mismatch("matched_index", IP_W'(m_axis_tdata[45:36]),
                                    IP_W'(want.matched_index));
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_fill_table();
        test_directed_routes();
        test_active_saturation();
        test_random_traffic();
        test_output_backpressure();
        wait_until_idle();
        // Room for any stray result from a last full walk.
        repeat (walk_length() + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_longest_prefix_route_lookup_core: PASS");
        else
            $display("tb_longest_prefix_route_lookup_core: FAIL");
        $finish;
    end

    // Watchdog: a lost result or a hung handshake ends up here.
    initial begin
        #2_000_000;
        $display("tb_longest_prefix_route_lookup_core: FAIL");
        $finish;
    end

endmodule
